FILE: src/bounded_edit_distance_defines.svh
// Assertion macros shared by the bounded edit distance block.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef BOUNDED_EDIT_DISTANCE_DEFINES_SVH
`define BOUNDED_EDIT_DISTANCE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BED_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bed_pkg.sv
// Shared constants, codes and types for the bounded edit distance block.
// No dependencies.
package bed_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = $clog2(MAX_LEN + 2);
    localparam int THR_W   = 5;
    localparam int DIST_W  = 6;
    localparam int CMD_W   = 2;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_COMPARE       = 2'd2,
        CMD_UNUSED        = 2'd3
    } bed_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } bed_state_t;

endpackage

FILE: src/bounded_edit_distance.sv
// Top level of the bounded edit distance block: word storage, row walker and result.
// Depends on bed_pkg, bed_ram and bounded_edit_distance_defines.svh.
`include "bounded_edit_distance_defines.svh"

// An append beat (command 0 or 1) is taken at once and busy stays low. A compare
// walks the matrix one row at a time, with a load step before each row and then
// one column per cycle, out of a row memory with a registered read. Busy stays
// high until the last row is walked or a row lies wholly above the threshold (only
// a finish step when either word is empty), and the result follows in the cycle
// after the last busy cycle. The result is shown for exactly one cycle with
// result_valid high and must be taken then; busy is already low in that cycle.
module bounded_edit_distance
    import bed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic              cfg_we,
    input  logic [THR_W-1:0]  cfg_wdata,
    output logic              result_valid,
    output logic [DIST_W-1:0] distance,
    output logic              exceeded,
    output logic              truncated
);

    bed_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len1_reg, len1_next;
    logic [LEN_W-1:0]  len2_reg, len2_next;
    logic              overflow_reg, overflow_next;
    logic [THR_W-1:0]  thr_reg;
    logic [LEN_W-1:0]  row_reg, row_next;
    logic [LEN_W-1:0]  col_reg, col_next;
    logic [CELL_W-1:0] left_reg, left_next;
    logic [CELL_W-1:0] diag_reg, diag_next;
    logic              all_above_reg, all_above_next;
    logic              stop_reg, stop_next;
    logic              valid_reg, valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              exc_reg, exc_next;
    logic              trunc_reg, trunc_next;

    logic              accept;
    logic              row_end;
    logic              cmp_empty;

    logic              w1_we, w2_we, w1_re, w2_re, pr_we, pr_re;
    logic [ADDR_W-1:0] w1_waddr, w2_waddr, w2_raddr, pr_waddr, pr_raddr;
    logic [CHAR_W-1:0] w1_rdata, w2_rdata;
    logic [CELL_W-1:0] pr_rdata;

    logic [CELL_W-1:0] up, cand_up, cand_left, cand_diag, cell_cost, cell_min;

    bed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_word (
        .clk   (clk),
        .we    (w1_we),
        .waddr (w1_waddr),
        .wdata (char_byte),
        .re    (w1_re),
        .raddr (ADDR_W'(row_reg - LEN_W'(1))),
        .rdata (w1_rdata)
    );

    bed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_word (
        .clk   (clk),
        .we    (w2_we),
        .waddr (w2_waddr),
        .wdata (char_byte),
        .re    (w2_re),
        .raddr (w2_raddr),
        .rdata (w2_rdata)
    );

    // Column j of the working row lives at address j - 1; column 0 is row_reg itself.
    bed_ram #(.WIDTH(CELL_W), .DEPTH(MAX_LEN)) u_prev_row (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (cell_cost),
        .re    (pr_re),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign row_end   = (col_reg == len2_reg);
    assign cmp_empty = (len1_reg == '0) || (len2_reg == '0);

    // The first row has never been written: its upper neighbour is the column index.
    assign up        = (row_reg == LEN_W'(1)) ? CELL_W'(col_reg) : pr_rdata;
    assign cand_up   = up + CELL_W'(1);
    assign cand_left = left_reg + CELL_W'(1);
    assign cand_diag = diag_reg + CELL_W'((w1_rdata != w2_rdata) ? 1 : 0);
    assign cell_min  = (cand_up < cand_left) ? cand_up : cand_left;
    assign cell_cost = (cell_min < cand_diag) ? cell_min : cand_diag;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_COMPARE))
                begin
                    state_next = cmp_empty ? ST_FINISH : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (row_end)
                begin
                    if ((all_above_reg && (cell_cost > thr_reg)) || (row_reg == len1_reg))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls and datapath.
    always_comb
    begin
        len1_next      = len1_reg;
        len2_next      = len2_reg;
        overflow_next  = overflow_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        all_above_next = all_above_reg;
        stop_next      = stop_reg;
        valid_next     = 1'b0;
        dist_next      = dist_reg;
        exc_next       = exc_reg;
        trunc_next     = trunc_reg;
        w1_we          = 1'b0;
        w2_we          = 1'b0;
        w1_re          = 1'b0;
        w2_re          = 1'b0;
        pr_we          = 1'b0;
        pr_re          = 1'b0;
        w1_waddr       = len1_reg[ADDR_W-1:0];
        w2_waddr       = len2_reg[ADDR_W-1:0];
        w2_raddr       = ADDR_W'(col_reg);
        pr_raddr       = ADDR_W'(col_reg);
        pr_waddr       = ADDR_W'(col_reg - LEN_W'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_APPEND_FIRST:
                        begin
                            if (len1_reg < LEN_W'(MAX_LEN))
                            begin
                                w1_we     = 1'b1;
                                len1_next = len1_reg + LEN_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        CMD_APPEND_SECOND:
                        begin
                            if (len2_reg < LEN_W'(MAX_LEN))
                            begin
                                w2_we     = 1'b1;
                                len2_next = len2_reg + LEN_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        CMD_COMPARE:
                        begin
                            row_next  = LEN_W'(1);
                            stop_next = 1'b0;
                            // With an empty word the distance is the other word's length.
                            left_next = (len2_reg == '0) ? CELL_W'(len1_reg)
                                                         : CELL_W'(len2_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                // Fetch this row's character and the first column's operands.
                w1_re          = 1'b1;
                w2_re          = 1'b1;
                pr_re          = 1'b1;
                w2_raddr       = '0;
                pr_raddr       = '0;
                col_next       = LEN_W'(1);
                left_next      = CELL_W'(row_reg);
                diag_next      = CELL_W'(row_reg - LEN_W'(1));
                all_above_next = 1'b1;
            end
            ST_RUN:
            begin
                pr_we          = 1'b1;
                left_next      = cell_cost;
                diag_next      = up;
                all_above_next = all_above_reg && (cell_cost > thr_reg);
                if (row_end)
                begin
                    stop_next = all_above_reg && (cell_cost > thr_reg);
                    row_next  = row_reg + LEN_W'(1);
                end
                else
                begin
                    w2_re    = 1'b1;
                    pr_re    = 1'b1;
                    col_next = col_reg + LEN_W'(1);
                end
            end
            ST_FINISH:
            begin
                valid_next    = 1'b1;
                dist_next     = stop_reg ? (DIST_W'(thr_reg) + DIST_W'(1))
                                         : DIST_W'(left_reg);
                exc_next      = stop_reg;
                trunc_next    = overflow_reg;
                len1_next     = '0;
                len2_next     = '0;
                overflow_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len1_reg     <= '0;
            len2_reg     <= '0;
            overflow_reg <= 1'b0;
            thr_reg      <= THR_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len1_reg     <= len1_next;
            len2_reg     <= len2_next;
            overflow_reg <= overflow_next;
            valid_reg    <= valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        left_reg      <= left_next;
        diag_reg      <= diag_next;
        all_above_reg <= all_above_next;
        stop_reg      <= stop_next;
        dist_reg      <= dist_next;
        exc_reg       <= exc_next;
        trunc_reg     <= trunc_next;
    end

    assign result_valid = valid_reg;
    assign distance     = dist_reg;
    assign exceeded     = exc_reg;
    assign truncated    = trunc_reg;

    `BED_ASSERT_SAME(a_result_when_free, result_valid, !busy,
                     "result beat shown while busy")
    `BED_ASSERT_SAME(a_col_in_range, state_reg == ST_RUN,
                     (col_reg >= LEN_W'(1)) && (col_reg <= len2_reg),
                     "column walker outside the second word")
    `BED_ASSERT_SAME(a_row_in_range, state_reg == ST_LOAD,
                     (row_reg >= LEN_W'(1)) && (row_reg <= len1_reg),
                     "row walker outside the first word")
    `BED_ASSERT_NEXT(a_load_then_run, state_reg == ST_LOAD, state_reg == ST_RUN,
                     "row load not followed by the column walk")

endmodule

FILE: src/bed_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
